FILE: design/ordered_timer_queue_defines.svh
// Assertion macros for the timer queue.
`ifndef ORDERED_TIMER_QUEUE_DEFINES_SVH
`define ORDERED_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define OTQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define OTQ_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OTQ_ASSERT(label, prop, msg)
`define OTQ_ASSERT_RST(label, prop, msg)
`endif

`endif

FILE: design/otq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package otq_pkg;

	localparam int EXP_W = 48;
	localparam int ID_W  = 32;
	localparam int DLY_W = 32;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_CHECK  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_MOVE,
		S_DONE
	} otq_state_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_CMP,
		CMD_MOVE
	} otq_cmd_t;

	typedef struct packed {
		logic [EXP_W-1:0] expire;
		logic [ID_W-1:0]  id;
	} otq_key_t;

	typedef struct packed {
		logic     valid;
		otq_key_t key;
	} otq_entry_t;

	typedef struct packed {
		otq_cmd_t cmd;
		logic     ins;
		logic     del;
		logic     pop;
	} otq_ctrl_t;

endpackage
`default_nettype wire

FILE: design/ordered_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// busy is high from the accepting edge until the result is out; the block takes a new request
// only after the last one is through. done rises with the result on the outputs.
// The steps are compare in every cell, shift the row of cells, and form sleep from the head.
// The receiver cannot stall; done is a one-cycle strobe.
// Reset clears all cells, the id counter and the sequencer at once; no clearing pass.
`include "ordered_timer_queue_defines.svh"
module ordered_timer_queue #(
	parameter int TIMER_SLOTS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  mode,
	input  wire  [47:0] now_ms,
	input  wire  [31:0] delay_ms,
	input  wire  [31:0] cancel_id,
	input  wire  [47:0] cancel_expire,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] timer_id,
	output logic [47:0] expire_ms,
	output logic [47:0] sleep_ms,
	output logic        queue_empty
);
	import otq_pkg::*;

	otq_state_t        state_q;
	otq_state_t        state_d;
	otq_ctrl_t         ctrl;
	logic [1:0]        mode_q;
	logic [EXP_W-1:0]  now_q;
	otq_key_t          key_q;
	otq_key_t          key_d;
	logic [ID_W-1:0]   next_id_q;
	logic [EXP_W:0]    sum;
	logic              accept;

	logic [1:0]        res_status_q;
	logic [ID_W-1:0]   res_id_q;
	logic [EXP_W-1:0]  res_exp_q;

	otq_entry_t        ent   [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] gt_v;
	logic [TIMER_SLOTS-1:0] match_v;
	logic [TIMER_SLOTS-1:0] valid_v;

	logic              found;
	logic              full;
	logic              due;
	logic              ins_ok;

	assign accept = start && !busy;

	always_comb begin
		sum = {1'b0, now_ms} + {{(EXP_W + 1 - DLY_W){1'b0}}, delay_ms};
		if (mode == MODE_ADD) begin
			key_d.expire = sum[EXP_W] ? {EXP_W{1'b1}} : sum[EXP_W-1:0];
			key_d.id     = next_id_q;
		end else begin
			key_d.expire = cancel_expire;
			key_d.id     = cancel_id;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			now_q  <= now_ms;
			key_q  <= key_d;
		end
	end

	// row of cells, head at index 0 holds the earliest key
	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		otq_entry_t left_ent;
		otq_entry_t right_ent;
		logic       left_gt;

		if (i == 0) begin : g_head
			assign left_ent = '0;
			assign left_gt  = 1'b0;
		end else begin : g_mid
			assign left_ent = ent[i-1];
			assign left_gt  = gt_v[i-1];
		end
		if (i == TIMER_SLOTS - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_body
			assign right_ent = ent[i+1];
		end

		otq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.key     (key_q),
			.left    (left_ent),
			.left_gt (left_gt),
			.right   (right_ent),
			.ent     (ent[i]),
			.gt      (gt_v[i]),
			.match   (match_v[i])
		);

		assign valid_v[i] = ent[i].valid;
	end

	assign found  = |match_v;
	assign full   = valid_v[TIMER_SLOTS-1];
	assign due    = ent[0].valid && (ent[0].key.expire <= now_q);
	assign ins_ok = !found && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		ctrl.cmd = CMD_HOLD;
		busy     = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctrl.cmd = CMD_CMP;
				state_d  = S_MOVE;
			end
			S_MOVE: begin
				ctrl.cmd = CMD_MOVE;
				ctrl.ins = (mode_q == MODE_ADD) && ins_ok;
				ctrl.del = (mode_q == MODE_CANCEL) && found;
				ctrl.pop = (mode_q == MODE_CHECK) && due;
				state_d  = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= '0;
		end else if (state_q == S_MOVE && mode_q == MODE_ADD && (found || !full)) begin
			next_id_q <= next_id_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MOVE) begin
			res_status_q <= ST_MISS;
			res_id_q     <= '0;
			res_exp_q    <= '0;
			case (mode_q)
				MODE_ADD: begin
					if (found || !full) begin
						res_status_q <= ST_OK;
						res_id_q     <= key_q.id;
						res_exp_q    <= key_q.expire;
					end else begin
						res_status_q <= ST_FULL;
					end
				end
				MODE_CANCEL: begin
					if (found) begin
						res_status_q <= ST_OK;
						res_id_q     <= key_q.id;
						res_exp_q    <= key_q.expire;
					end
				end
				MODE_CHECK: begin
					if (due) begin
						res_status_q <= ST_OK;
						res_id_q     <= ent[0].key.id;
						res_exp_q    <= ent[0].key.expire;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == S_DONE);
		end
	end

	// head of the row is settled now; report distance to its expiry
	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			status      <= res_status_q;
			timer_id    <= res_id_q;
			expire_ms   <= res_exp_q;
			queue_empty <= !ent[0].valid;
			if (!ent[0].valid) begin
				sleep_ms <= {EXP_W{1'b1}};
			end else if (ent[0].key.expire > now_q) begin
				sleep_ms <= ent[0].key.expire - now_q;
			end else begin
				sleep_ms <= '0;
			end
		end
	end

	`OTQ_ASSERT(a_accept_busy, accept |=> busy, "request accepted but block not busy")
	`OTQ_ASSERT_RST(a_packed, ((valid_v & (valid_v + 1'b1)) == '0), "cells not packed at head")
	`OTQ_ASSERT(a_done_pulse, done |=> !done, "done strobe longer than one cycle")
	`OTQ_ASSERT(a_done_idle, done |-> !busy, "result shown while a request is in flight")

endmodule
`default_nettype wire

FILE: design/otq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module otq_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  otq_pkg::otq_ctrl_t  ctrl,
	input  otq_pkg::otq_key_t   key,
	input  otq_pkg::otq_entry_t left,
	input  wire                 left_gt,
	input  otq_pkg::otq_entry_t right,
	output otq_pkg::otq_entry_t ent,
	output logic                gt,
	output logic                match
);
	import otq_pkg::*;

	logic     valid_q;
	otq_key_t key_q;
	logic     lt_q;
	logic     eq_q;
	logic     lt;
	logic     eq;
	logic     ge;
	logic     take_new;
	logic     take_left;
	logic     take_right;

	// request key strictly before the stored key
	always_comb begin
		if (key.expire != key_q.expire) begin
			lt = key.expire < key_q.expire;
		end else begin
			lt = key.id < key_q.id;
		end
		eq = (key == key_q);
	end

	assign gt    = !valid_q || lt_q;
	assign ge    = valid_q && (lt_q || eq_q);
	assign match = valid_q && eq_q;

	assign take_new   = ctrl.ins && gt && !left_gt;
	assign take_left  = ctrl.ins && gt && left_gt;
	assign take_right = (ctrl.del && ge) || ctrl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			case (ctrl.cmd)
				CMD_CMP: begin
					lt_q <= lt;
					eq_q <= eq;
				end
				CMD_MOVE: begin
					if (take_new) begin
						valid_q <= 1'b1;
					end else if (take_left) begin
						valid_q <= left.valid;
					end else if (take_right) begin
						valid_q <= right.valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmd == CMD_MOVE) begin
			if (take_new) begin
				key_q <= key;
			end else if (take_left) begin
				key_q <= left.key;
			end else if (take_right) begin
				key_q <= right.key;
			end
		end
	end

	assign ent.valid = valid_q;
	assign ent.key   = key_q;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import otq_pkg::*;

	localparam int          SLOTS       = 32;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;
	localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam int          ITEM_TARGET = 1350;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          PRINT_LIMIT = 20;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] id;
		logic [47:0] expire;
		logic [47:0] sleep;
		logic        empty;
	} timer_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [1:0]  mode;
	logic [47:0] now_ms;
	logic [31:0] delay_ms;
	logic [31:0] cancel_id;
	logic [47:0] cancel_expire;
	wire         busy;
	wire         done;
	wire  [1:0]  status;
	wire  [31:0] timer_id;
	wire  [47:0] expire_ms;
	wire  [47:0] sleep_ms;
	wire         queue_empty;

	// shadow timer table
	logic        slot_used   [SLOTS];
	logic [47:0] slot_expire [SLOTS];
	logic [31:0] slot_id     [SLOTS];
	logic [31:0] id_counter;

	timer_result_t pending_results[$];
	timer_result_t head_result;
	logic [47:0]   wall_ms;
	bit            no_idle;
	int            error_count;
	int            requests_sent;
	int            results_seen;
	int            cycle_count;
	int            added_count;
	int            full_count;
	int            fired_count;
	int            cancelled_count;
	int            miss_count;

	ordered_timer_queue #(
		.TIMER_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.now_ms(now_ms),
		.delay_ms(delay_ms),
		.cancel_id(cancel_id),
		.cancel_expire(cancel_expire),
		.done(done),
		.status(status),
		.timer_id(timer_id),
		.expire_ms(expire_ms),
		.sleep_ms(sleep_ms),
		.queue_empty(queue_empty)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	function automatic bit key_earlier(logic [47:0] ea, logic [31:0] ia,
			logic [47:0] eb, logic [31:0] ib);
		return (ea != eb) ? (ea < eb) : (ia < ib);
	endfunction

	function automatic int head_slot();
		int best;
		int i;
		best = -1;
		for (i = 0; i < SLOTS; i++)
			if (slot_used[i] && (best < 0 ||
					key_earlier(slot_expire[i], slot_id[i], slot_expire[best], slot_id[best])))
				best = i;
		return best;
	endfunction

	function automatic int match_slot(logic [31:0] id, logic [47:0] due);
		int i;
		for (i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_id[i] == id && slot_expire[i] == due)
				return i;
		return -1;
	endfunction

	function automatic int live_count();
		int i;
		int n;
		n = 0;
		for (i = 0; i < SLOTS; i++)
			if (slot_used[i])
				n++;
		return n;
	endfunction

	function automatic int pick_live_slot();
		int live[$];
		int i;
		for (i = 0; i < SLOTS; i++)
			if (slot_used[i])
				live.push_back(i);
		if (live.size() == 0)
			return -1;
		return live[$urandom_range(live.size() - 1)];
	endfunction

	// Apply one request to the shadow table and return the result it must produce.
	function automatic timer_result_t apply_request(logic [1:0] op, logic [47:0] now,
			logic [31:0] delay, logic [31:0] cid, logic [47:0] cexp);
		timer_result_t r;
		logic [48:0]   sum;
		logic [47:0]   due;
		int            s;
		int            i;
		int            free_slot;
		r = '0;
		r.status = ST_MISS;
		case (op)
		MODE_ADD: begin
			sum = {1'b0, now} + {17'd0, delay};
			due = sum[48] ? TIME_MAX : sum[47:0];
			s = match_slot(id_counter, due);
			free_slot = -1;
			for (i = SLOTS - 1; i >= 0; i--)
				if (!slot_used[i])
					free_slot = i;
			// an existing identical key wins over the full test
			if (s >= 0 || free_slot >= 0) begin
				if (s < 0) begin
					slot_used[free_slot] = 1'b1;
					slot_expire[free_slot] = due;
					slot_id[free_slot] = id_counter;
				end
				r.status = ST_OK;
				r.id = id_counter;
				r.expire = due;
				id_counter = id_counter + 32'd1;
			end else begin
				r.status = ST_FULL;
			end
		end
		MODE_CANCEL: begin
			s = match_slot(cid, cexp);
			if (s >= 0) begin
				slot_used[s] = 1'b0;
				r.status = ST_OK;
				r.id = cid;
				r.expire = cexp;
			end
		end
		MODE_CHECK: begin
			s = head_slot();
			if (s >= 0 && slot_expire[s] <= now) begin
				slot_used[s] = 1'b0;
				r.status = ST_OK;
				r.id = slot_id[s];
				r.expire = slot_expire[s];
			end
		end
		default: begin
		end
		endcase
		s = head_slot();
		if (s < 0) begin
			r.sleep = TIME_MAX;
			r.empty = 1'b1;
		end else begin
			r.sleep = (slot_expire[s] > now) ? slot_expire[s] - now : '0;
			r.empty = 1'b0;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(99);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 96)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic send_request(logic [1:0] op, logic [47:0] now, logic [31:0] delay,
			logic [31:0] cid, logic [47:0] cexp);
		int            gap;
		timer_result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= op;
		now_ms <= now;
		delay_ms <= delay;
		cancel_id <= cid;
		cancel_expire <= cexp;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		r = apply_request(op, now, delay, cid, cexp);
		pending_results.push_back(r);
		requests_sent++;
		if (r.status == ST_FULL)
			full_count++;
		else if (r.status == ST_MISS)
			miss_count++;
		else if (op == MODE_ADD)
			added_count++;
		else if (op == MODE_CANCEL)
			cancelled_count++;
		else
			fired_count++;
	endtask

	// Hold off new requests until every outstanding result has come back.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, status %0d id %0h",
					status, timer_id));
			end else begin
				head_result = pending_results.pop_front();
				if (status !== head_result.status)
					report_mismatch($sformatf("status got %0d want %0d",
						status, head_result.status));
				if (timer_id !== head_result.id)
					report_mismatch($sformatf("timer_id got %0h want %0h",
						timer_id, head_result.id));
				if (expire_ms !== head_result.expire)
					report_mismatch($sformatf("expire_ms got %0h want %0h",
						expire_ms, head_result.expire));
				if (sleep_ms !== head_result.sleep)
					report_mismatch($sformatf("sleep_ms got %0h want %0h",
						sleep_ms, head_result.sleep));
				if (queue_empty !== head_result.empty)
					report_mismatch($sformatf("queue_empty got %0b want %0b",
						queue_empty, head_result.empty));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_results.size());
		$display("testbench NOT OK");
		$finish;
	end

	task automatic test_edges();
		logic [31:0] base;
		base = id_counter;
		send_request(MODE_CHECK, '0, '0, '0, '0);
		send_request(MODE_CANCEL, '0, '0, '1, TIME_MAX);
		send_request(MODE_UNUSED, TIME_MAX, '1, '1, TIME_MAX);
		send_request(MODE_ADD, '0, '0, '0, '0);
		// same expiry, ordered by id
		send_request(MODE_ADD, '0, '0, '0, '0);
		// expiry saturates
		send_request(MODE_ADD, TIME_MAX, '1, '0, '0);
		send_request(MODE_ADD, TIME_MAX - 2, 32'd1, '0, '0);
		// lands exactly on the top without saturating
		send_request(MODE_ADD, TIME_MAX - 10, 32'd10, '0, '0);
		send_request(MODE_CHECK, '0, '0, '0, '0);
		send_request(MODE_CANCEL, '0, '0, base + 32'd1, 48'd1);
		send_request(MODE_CANCEL, '0, '0, base + 32'd2, '0);
		send_request(MODE_CANCEL, '0, '0, base + 32'd1, '0);
		send_request(MODE_CHECK, 48'd5, '0, '0, '0);
		send_request(MODE_CHECK, TIME_MAX - 2, '0, '0, '0);
		send_request(MODE_UNUSED, 48'h5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			48'hAAAA_AAAA_AAAA);
		send_request(MODE_CHECK, TIME_MAX - 1, '0, '0, '0);
		send_request(MODE_CHECK, TIME_MAX, '0, '0, '0);
		send_request(MODE_CHECK, TIME_MAX, '0, '0, '0);
		send_request(MODE_CHECK, TIME_MAX, '0, '0, '0);
		send_request(MODE_ADD, 48'h5555_5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
			48'h5555_5555_5555);
		send_request(MODE_ADD, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
			48'hAAAA_AAAA_AAAA);
		send_request(MODE_CHECK, '0, '0, '0, '0);
		send_request(MODE_CHECK, TIME_MAX, '0, '0, '0);
		send_request(MODE_CHECK, TIME_MAX, '0, '0, '0);
	endtask

	task automatic test_table_full();
		int fill;
		int n;
		int s;
		fill = SLOTS - live_count() + 3;
		// short delays at a fixed time give many equal expiries
		repeat (fill)
			send_request(MODE_ADD, wall_ms, $urandom_range(8), $urandom, rand48());
		s = pick_live_slot();
		if (s >= 0)
			send_request(MODE_CANCEL, rand48(), $urandom, slot_id[s], slot_expire[s]);
		send_request(MODE_ADD, wall_ms, $urandom_range(8), $urandom, rand48());
		send_request(MODE_ADD, wall_ms, $urandom_range(8), $urandom, rand48());
		for (n = 0; n < 2 * SLOTS; n++) begin
			wall_ms = wall_ms + $urandom_range(3);
			send_request(MODE_CHECK, wall_ms, $urandom, $urandom, rand48());
		end
		while (live_count() > 0)
			send_request(MODE_CHECK, TIME_MAX, $urandom, $urandom, rand48());
		send_request(MODE_CHECK, TIME_MAX, $urandom, $urandom, rand48());
	endtask

	task automatic test_random_traffic(int count);
		int          n;
		int          roll;
		int          pick;
		int          s;
		logic [1:0]  op;
		logic [47:0] now;
		logic [47:0] cexp;
		logic [31:0] delay;
		logic [31:0] cid;
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 2)
				wall_ms = rand48();
			else if (roll < 3)
				wall_ms = TIME_MAX - $urandom_range(1000);
			else
				wall_ms = wall_ms + $urandom_range(40);
			now = wall_ms;
			delay = $urandom;
			cid = $urandom;
			cexp = rand48();
			roll = $urandom_range(99);
			if (roll < 38) begin
				op = MODE_ADD;
				pick = $urandom_range(99);
				if (pick < 70)
					delay = $urandom_range(300);
				else if (pick < 85)
					delay = '0;
				else if (pick < 90)
					delay = '1;
			end else if (roll < 60) begin
				op = MODE_CANCEL;
				s = pick_live_slot();
				if (s >= 0) begin
					cid = slot_id[s];
					cexp = slot_expire[s];
					// flip one key bit to get a near miss
					if (roll >= 53) begin
						pick = $urandom_range(79);
						if (pick < 32)
							cid[pick] = ~cid[pick];
						else
							cexp[pick - 32] = ~cexp[pick - 32];
					end
				end
			end else if (roll < 96) begin
				op = MODE_CHECK;
				if ($urandom_range(9) == 0)
					now = wall_ms + $urandom_range(2000);
			end else begin
				op = MODE_UNUSED;
			end
			send_request(op, now, delay, cid, cexp);
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_ADD;
		now_ms = '0;
		delay_ms = '0;
		cancel_id = '0;
		cancel_expire = '0;
		for (i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_expire[i] = '0;
			slot_id[i] = '0;
		end
		id_counter = '0;
		wall_ms = '0;
		no_idle = 1'b0;
		error_count = 0;
		requests_sent = 0;
		results_seen = 0;
		added_count = 0;
		full_count = 0;
		fired_count = 0;
		cancelled_count = 0;
		miss_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edges();
		drain_results();
		test_table_full();
		drain_results();
		while (requests_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(3) == 0);
			if ($urandom_range(4) == 0)
				test_table_full();
			else
				test_random_traffic($urandom_range(150, 40));
			if ($urandom_range(2) == 0)
				drain_results();
		end
		no_idle = 1'b0;
		drain_results();
		repeat (8) @(posedge clk);

		$display("ran %0d requests, %0d results: %0d added, %0d rejected full, %0d fired,",
			requests_sent, results_seen, added_count, full_count, fired_count);
		$display("%0d cancelled, %0d not found or not due, %0d mismatches in %0d cycles",
			cancelled_count, miss_count, error_count, cycle_count);
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
